// ===== rtl/gss_pkg.sv =====
package gss_pkg;

   localparam int SCORE_BITS = 16;
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int TOTAL_BITS = SCORE_BITS + COUNT_BITS;
   localparam int GAP_BITS   = 16;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 3;
   localparam int STEP_SPAN  = (TIME_BITS > SCORE_BITS) ? TIME_BITS : SCORE_BITS;
   localparam int STEP_BITS  = $clog2(STEP_SPAN);

   localparam logic [GAP_BITS-1:0] GAP_LOW  = GAP_BITS'(250);
   localparam logic [GAP_BITS-1:0] GAP_HIGH = GAP_BITS'(60000);

   localparam logic REG_ENABLE = 1'b0;
   localparam logic REG_GAP    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GAP,
      ST_DIV,
      ST_DONE
   } gss_state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  event_time_ms;
      logic [SCORE_BITS-1:0] score;
   } gss_req_type;

   typedef struct packed {
      logic                  sampled;
      logic                  skipped;
      logic [COUNT_BITS-1:0] detection_count;
      logic [COUNT_BITS-1:0] sample_count;
      logic [COUNT_BITS-1:0] skip_count;
      logic [SCORE_BITS-1:0] score_min;
      logic [SCORE_BITS-1:0] score_max;
      logic [SCORE_BITS-1:0] score_mean;
      logic [SCORE_BITS-1:0] score_last;
   } gss_rsp_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (c == '1) ? c : c + COUNT_BITS'(1);
   endfunction

endpackage

// ===== rtl/gated_score_statistics.sv =====
// gated_score_statistics
// Input channel req_valid/req_ready/req_data carries one detection event
// (timestamp, score); every event gives exactly one result on
// rsp_valid/rsp_ready/rsp_data with the statistics after that event.
// The csr_ APB port holds the enable bit (address 0, writing 1 clears all
// statistics) and the minimum sample gap (address 4, clamped to 250..60000).
// One event is processed at a time. A disabled event goes from idle
// straight to the done state, which loads the output register. An enabled
// event first runs a bit-serial modular subtract and gap compare, one
// timestamp bit per cycle; a sample then runs a restoring divide for the
// mean, one quotient bit per cycle, unless its count is saturated, while a
// skipped event goes straight to the done state. The done state loads the
// result into the output register before the next event is taken, so a new
// event is never taken before the last one is through. req_ready is high
// when the sequencer is idle.
// The result sits in an output register, so the next event is taken while
// a stalled result waits; a finished event then holds until the output
// register frees up. Reset (synchronous) disables the block, sets the gap
// to 250, clears all statistics and empties the output register.
module gated_score_statistics
   import gss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gss_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gss_rsp_type          rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   gss_state_type          state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   enable_ff, enable_in;
   logic [GAP_BITS-1:0]    gap_ff, gap_in;

   logic [COUNT_BITS-1:0]  det_ff, det_in;
   logic [COUNT_BITS-1:0]  samples_ff, samples_in;
   logic [COUNT_BITS-1:0]  skips_ff, skips_in;
   logic [TIME_BITS-1:0]   last_time_ff, last_time_in;
   logic [SCORE_BITS-1:0]  low_ff, low_in;
   logic [SCORE_BITS-1:0]  high_ff, high_in;
   logic [SCORE_BITS-1:0]  latest_ff, latest_in;
   logic [SCORE_BITS-1:0]  mean_ff, mean_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;

   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SCORE_BITS-1:0]  score_ff, score_in;
   logic [TIME_BITS-1:0]   now_sh_ff, now_sh_in;
   logic [TIME_BITS-1:0]   last_sh_ff, last_sh_in;
   logic [TIME_BITS-1:0]   gap_sh_ff, gap_sh_in;
   logic                   borrow_ff, borrow_in;
   logic                   lt_ff, lt_in;
   logic                   took_ff, took_in;
   logic                   gated_ff, gated_in;

   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  div_ff, div_in;
   logic [SCORE_BITS-1:0]  lo_sh_ff, lo_sh_in;
   logic [SCORE_BITS-1:0]  q_sh_ff, q_sh_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   gss_rsp_type            rsp_ff, rsp_in;

   logic                   csr_write;
   logic [GAP_BITS-1:0]    gap_wr;
   logic                   bit_a, bit_b, bit_d, bit_g, lt_next;
   logic [TOTAL_BITS-1:0]  total_sum;
   logic [COUNT_BITS-1:0]  samples_next;
   logic [COUNT_BITS:0]    trial, trial_sub;
   logic                   trial_ge;
   logic [SCORE_BITS-1:0]  q_next;
   logic                   first, frozen;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      case (csr_paddr[2])
         REG_ENABLE: csr_prdata = DATA_BITS'(enable_ff);
         REG_GAP:    csr_prdata = DATA_BITS'(gap_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      gap_wr = csr_pwdata[GAP_BITS-1:0];
      if (gap_wr < GAP_LOW) begin
         gap_wr = GAP_LOW;
      end else if (gap_wr > GAP_HIGH) begin
         gap_wr = GAP_HIGH;
      end
   end

   // serial modular subtract and compare, lsb first
   assign bit_a   = now_sh_ff[0];
   assign bit_b   = last_sh_ff[0];
   assign bit_d   = bit_a ^ bit_b ^ borrow_ff;
   assign bit_g   = gap_sh_ff[0];
   assign lt_next = (bit_d != bit_g) ? bit_g : lt_ff;

   assign first        = (samples_ff == '0);
   assign frozen       = (samples_ff == '1);
   assign samples_next = sat_inc(samples_ff);
   assign total_sum    = total_ff + TOTAL_BITS'(score_ff);

   // restoring divide, one quotient bit per step
   assign trial     = {rem_ff, lo_sh_ff[SCORE_BITS-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign trial_ge  = (trial >= {1'b0, div_ff});
   assign q_next    = {q_sh_ff[SCORE_BITS-2:0], trial_ge};

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      enable_in    = enable_ff;
      gap_in       = gap_ff;
      det_in       = det_ff;
      samples_in   = samples_ff;
      skips_in     = skips_ff;
      last_time_in = last_time_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      latest_in    = latest_ff;
      mean_in      = mean_ff;
      total_in     = total_ff;
      now_in       = now_ff;
      score_in     = score_ff;
      now_sh_in    = now_sh_ff;
      last_sh_in   = last_sh_ff;
      gap_sh_in    = gap_sh_ff;
      borrow_in    = borrow_ff;
      lt_in        = lt_ff;
      took_in      = took_ff;
      gated_in     = gated_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      lo_sh_in     = lo_sh_ff;
      q_sh_in      = q_sh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         case (csr_paddr[2])
            REG_ENABLE: begin
               enable_in = csr_pwdata[0];
               if (csr_pwdata[0]) begin
                  det_in       = '0;
                  samples_in   = '0;
                  skips_in     = '0;
                  last_time_in = '0;
                  low_in       = '0;
                  high_in      = '0;
                  latest_in    = '0;
                  mean_in      = '0;
                  total_in     = '0;
               end
            end
            REG_GAP: gap_in = gap_wr;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in     = req_data.event_time_ms;
               score_in   = req_data.score;
               now_sh_in  = req_data.event_time_ms;
               last_sh_in = last_time_ff;
               gap_sh_in  = TIME_BITS'(gap_ff);
               borrow_in  = 1'b0;
               lt_in      = 1'b0;
               step_in    = '0;
               took_in    = 1'b0;
               gated_in   = 1'b0;
               state_in   = enable_ff ? ST_GAP : ST_DONE;
            end
         end
         ST_GAP: begin
            now_sh_in  = now_sh_ff >> 1;
            last_sh_in = last_sh_ff >> 1;
            gap_sh_in  = gap_sh_ff >> 1;
            borrow_in  = (~bit_a & bit_b) | (~(bit_a ^ bit_b) & borrow_ff);
            lt_in      = lt_next;
            step_in    = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(TIME_BITS - 1)) begin
               det_in = sat_inc(det_ff);
               if (!first && lt_next) begin
                  skips_in = sat_inc(skips_ff);
                  gated_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  took_in      = 1'b1;
                  samples_in   = samples_next;
                  last_time_in = now_ff;
                  latest_in    = score_ff;
                  if (first || score_ff < low_ff) begin
                     low_in = score_ff;
                  end
                  if (first || score_ff > high_ff) begin
                     high_in = score_ff;
                  end
                  if (!frozen) begin
                     total_in = total_sum;
                     rem_in   = total_sum[TOTAL_BITS-1:SCORE_BITS];
                     lo_sh_in = total_sum[SCORE_BITS-1:0];
                     div_in   = samples_next;
                     q_sh_in  = '0;
                     step_in  = '0;
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in   = trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            lo_sh_in = lo_sh_ff << 1;
            q_sh_in  = q_next;
            step_in  = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SCORE_BITS - 1)) begin
               mean_in  = q_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.sampled         = took_ff;
               rsp_in.skipped         = gated_ff;
               rsp_in.detection_count = det_ff;
               rsp_in.sample_count    = samples_ff;
               rsp_in.skip_count      = skips_ff;
               rsp_in.score_min       = low_ff;
               rsp_in.score_max       = high_ff;
               rsp_in.score_mean      = mean_ff;
               rsp_in.score_last      = latest_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         enable_ff    <= 1'b0;
         gap_ff       <= GAP_LOW;
         det_ff       <= '0;
         samples_ff   <= '0;
         skips_ff     <= '0;
         last_time_ff <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         latest_ff    <= '0;
         mean_ff      <= '0;
         total_ff     <= '0;
         took_ff      <= 1'b0;
         gated_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         enable_ff    <= enable_in;
         gap_ff       <= gap_in;
         det_ff       <= det_in;
         samples_ff   <= samples_in;
         skips_ff     <= skips_in;
         last_time_ff <= last_time_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         latest_ff    <= latest_in;
         mean_ff      <= mean_in;
         total_ff     <= total_in;
         took_ff      <= took_in;
         gated_ff     <= gated_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      score_ff   <= score_in;
      now_sh_ff  <= now_sh_in;
      last_sh_ff <= last_sh_in;
      gap_sh_ff  <= gap_sh_in;
      borrow_ff  <= borrow_in;
      lt_ff      <= lt_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      lo_sh_ff   <= lo_sh_in;
      q_sh_ff    <= q_sh_in;
      rsp_ff     <= rsp_in;
   end

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (samples_ff <= det_ff) && (skips_ff <= det_ff))
      else $error("sample or skip count above detection count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("minimum score above maximum score");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_ff != '0) && (rem_ff < div_ff))
      else $error("divider remainder out of range");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.sampled && rsp_ff.skipped))
      else $error("result both sampled and skipped");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result lost while output stalled");

endmodule

// ===== test/tb_top.sv =====
module tb_top
   import gss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 20000;
   localparam int SEGMENTS     = 8;
   localparam int SEGMENT_SIZE = 215;

   localparam logic [ADDR_BITS-1:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};
   localparam logic [ADDR_BITS-1:0] ADDR_GAP    = {REG_GAP, 2'b00};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   gss_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   gss_rsp_type          rsp_data;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [DATA_BITS-1:0] csr_pwdata = '0;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   gss_req_type event_queue[$];
   gss_rsp_type predicted_stats[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int idle_cycles = 0;
   int results_seen = 0;
   int samples_seen = 0;
   int skips_seen = 0;
   int disabled_seen = 0;
   int settings_seen = 0;

   logic [31:0] stamp_ms = '0;

   // predictor state
   logic                  enable_cfg = 1'b0;
   logic [GAP_BITS-1:0]   gap_cfg = GAP_LOW;
   logic [COUNT_BITS-1:0] detections = '0;
   logic [COUNT_BITS-1:0] samples = '0;
   logic [COUNT_BITS-1:0] rejections = '0;
   logic [TIME_BITS-1:0]  last_time = '0;
   logic [SCORE_BITS-1:0] low_score = '0;
   logic [SCORE_BITS-1:0] high_score = '0;
   logic [SCORE_BITS-1:0] recent_score = '0;
   logic [SCORE_BITS-1:0] avg_score = '0;
   logic [TOTAL_BITS-1:0] running_sum = '0;

   gated_score_statistics dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      bump = (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic void clear_stats();
      detections = '0;
      samples = '0;
      rejections = '0;
      last_time = '0;
      low_score = '0;
      high_score = '0;
      recent_score = '0;
      avg_score = '0;
      running_sum = '0;
   endfunction

   function automatic void apply_setting(input logic [ADDR_BITS-1:0] addr,
                                         input logic [DATA_BITS-1:0] data);
      logic [GAP_BITS-1:0] g;
      if (addr == ADDR_ENABLE) begin
         enable_cfg = data[0];
         if (data[0]) begin
            clear_stats();
         end
      end else if (addr == ADDR_GAP) begin
         g = data[GAP_BITS-1:0];
         if (g < GAP_LOW) begin
            g = GAP_LOW;
         end
         if (g > GAP_HIGH) begin
            g = GAP_HIGH;
         end
         gap_cfg = g;
      end
   endfunction

   function automatic void advance_statistics(input gss_req_type ev);
      gss_rsp_type r;
      logic [TIME_BITS-1:0] elapsed;
      logic first;
      logic frozen;
      r = '0;
      if (enable_cfg) begin
         detections = bump(detections);
         elapsed = ev.event_time_ms - last_time;
         if (samples != 0 && elapsed < TIME_BITS'(gap_cfg)) begin
            rejections = bump(rejections);
            r.skipped = 1'b1;
         end else begin
            first = (samples == 0);
            frozen = (samples == '1);
            r.sampled = 1'b1;
            samples = bump(samples);
            last_time = ev.event_time_ms;
            recent_score = ev.score;
            if (first || ev.score < low_score) begin
               low_score = ev.score;
            end
            if (first || ev.score > high_score) begin
               high_score = ev.score;
            end
            if (!frozen) begin
               running_sum = running_sum + TOTAL_BITS'(ev.score);
               avg_score = SCORE_BITS'(running_sum / TOTAL_BITS'(samples));
            end
         end
      end
      r.detection_count = detections;
      r.sample_count = samples;
      r.skip_count = rejections;
      r.score_min = low_score;
      r.score_max = high_score;
      r.score_mean = avg_score;
      r.score_last = recent_score;
      predicted_stats.push_back(r);
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_statistics(req_data);
         end
         if (!req_valid || req_ready) begin
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= event_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      gss_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.sampled) samples_seen++;
            if (rsp_data.skipped) skips_seen++;
            if (!rsp_data.sampled && !rsp_data.skipped) disabled_seen++;
            if (predicted_stats.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               want = predicted_stats.pop_front();
               check_field("sampled", want.sampled, rsp_data.sampled);
               check_field("skipped", want.skipped, rsp_data.skipped);
               check_field("detection_count", want.detection_count,
                           rsp_data.detection_count);
               check_field("sample_count", want.sample_count, rsp_data.sample_count);
               check_field("skip_count", want.skip_count, rsp_data.skip_count);
               check_field("score_min", want.score_min, rsp_data.score_min);
               check_field("score_max", want.score_max, rsp_data.score_max);
               check_field("score_mean", want.score_mean, rsp_data.score_mean);
               check_field("score_last", want.score_last, rsp_data.score_last);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(input logic [ADDR_BITS-1:0] addr,
                            input logic [DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      apply_setting(addr, data);
      settings_seen++;
      // register readback after the transfer
      @(negedge clock);
      check_field("csr_prdata",
                  (addr == ADDR_ENABLE) ? 64'(enable_cfg) : 64'(gap_cfg),
                  csr_prdata);
   endtask

   task automatic push_event(input logic [TIME_BITS-1:0] t,
                             input logic [SCORE_BITS-1:0] s);
      gss_req_type ev;
      ev.event_time_ms = t;
      ev.score = s;
      event_queue.push_back(ev);
   endtask

   task automatic drain();
      while (event_queue.size() != 0 || req_valid || predicted_stats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_random_events(input int count);
      logic [31:0] step;
      logic [15:0] s;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         // the largest share of steps lands near the gap edge so both sides of the gate get hit
         if (pick < 40) step = gap_cfg + $urandom_range(20) - 10;
         else if (pick < 65) step = $urandom_range(gap_cfg - 1);
         else if (pick < 85) step = gap_cfg + $urandom_range(5000);
         else if (pick < 95) step = $urandom;
         else step = 0;
         if (pick >= 97) stamp_ms = $urandom;
         else stamp_ms = stamp_ms + step;
         pick = $urandom_range(99);
         if (pick < 10) s = '0;
         else if (pick < 20) s = '1;
         else s = 16'($urandom);
         push_event(stamp_ms, s);
      end
   endtask

   initial begin
      logic [DATA_BITS-1:0] raw;
      int kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // disabled after reset
      push_event(32'h0, 16'hffff);
      push_event(32'hffff_ffff, 16'h0);
      drain();

      // gap below range, first sample at time zero, wrapped differences
      csr_write(ADDR_GAP, 32'd0);
      csr_write(ADDR_ENABLE, 32'd1);
      @(negedge clock);
      push_event(32'd0, 16'h8000);
      push_event(32'd249, 16'hffff);
      push_event(32'd250, 16'h0000);
      push_event(32'hffff_fff0, 16'h1234);
      push_event(32'h0000_0010, 16'h7fff);
      push_event(32'h0000_00f0, 16'hffff);
      push_event(32'h0000_01e9, 16'h0001);
      drain();

      // gap above range, clear by enable
      csr_write(ADDR_GAP, 32'hffff_ffff);
      csr_write(ADDR_ENABLE, 32'hffff_ffff);
      @(negedge clock);
      push_event(32'd1000, 16'h0001);
      push_event(32'd60999, 16'h0002);
      push_event(32'd61000, 16'h0003);
      push_event(32'd121000, 16'haaaa);
      push_event(32'h5555_5555, 16'h5555);
      drain();

      // disable keeps the statistics
      csr_write(ADDR_ENABLE, 32'd0);
      @(negedge clock);
      push_event(32'd12345, 16'h4321);
      push_event(32'd0, 16'h0000);
      drain();

      // exact low gap across the wrap
      csr_write(ADDR_GAP, 32'd250);
      csr_write(ADDR_ENABLE, 32'd1);
      @(negedge clock);
      push_event(32'hffff_ffff, 16'hffff);
      push_event(32'd249, 16'h0000);
      push_event(32'd248, 16'h0100);
      drain();

      stamp_ms = $urandom;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         kind = $urandom_range(3);
         raw = $urandom;
         if (kind == 0) raw[15:0] = 16'($urandom_range(249));
         else if (kind == 1) raw[15:0] = 16'($urandom_range(16'hffff, 60000));
         else if (kind == 2) raw[15:0] = (seg % 2) ? GAP_HIGH : GAP_LOW;
         else raw[15:0] = 16'($urandom_range(60000, 250));
         csr_write(ADDR_GAP, raw);
         raw = $urandom;
         raw[0] = 1'b1;
         csr_write(ADDR_ENABLE, raw);
         @(negedge clock);
         queue_random_events(SEGMENT_SIZE);
         drain();
         raw = $urandom;
         raw[0] = 1'b0;
         csr_write(ADDR_ENABLE, raw);
         @(negedge clock);
         queue_random_events(4);
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (60) @(negedge clock);

      $display("covered %0d events over %0d register writes and four handshake modes",
               results_seen, settings_seen);
      $display("  %0d samples, %0d gated skips, %0d while disabled",
               samples_seen, skips_seen, disabled_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
